/* sv/roit_pkg.sv */
// Shared types, codes and sizes for the record offset index table.
// Used by every module of the block; depends on nothing else.
package roit_pkg;

	localparam int DEF_MAX_RECORDS = 1024;
	localparam int DEF_OFFSET_BITS = 24;

	localparam int CMD_W   = 3;
	localparam int LEN_W   = 16;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 24;
	localparam int ADDR_W  = 32;
	localparam int BYTES_W = 24;
	localparam int EB_W    = 16;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SPLIT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_MULT  = 3'd4;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BYTES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_QUERY,
		OP_LOCATE,
		OP_SPLIT,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [LEN_W-1:0]  length;
		logic [IDX_W-1:0]  index;
		logic [POS_W-1:0]  position;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIV,
		ST_GOT_START,
		ST_GOT_END,
		ST_SEARCH,
		ST_PROBE,
		ST_FIN
	} state_t;

endpackage

/* sv/roit_front.sv */
// Front end: takes input transfers, decodes the command and queues the item.
// Depends on roit_pkg.
module roit_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [roit_pkg::CMD_W-1:0]  command,
	input  logic [roit_pkg::LEN_W-1:0]  length,
	input  logic [roit_pkg::IDX_W-1:0]  index,
	input  logic [roit_pkg::POS_W-1:0]  position,
	output roit_pkg::queue_head_t       head,
	input  logic                        pop
);
	import roit_pkg::*;

	item_t       slot_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       dec;

	always_comb begin
		dec.length   = length;
		dec.index    = index;
		dec.position = position;
		unique case (command)
			CMD_APPEND: dec.op = OP_APPEND;
			CMD_QUERY:  dec.op = OP_QUERY;
			CMD_LOCATE: dec.op = OP_LOCATE;
			CMD_SPLIT:  dec.op = OP_SPLIT;
			CMD_CLEAR:  dec.op = OP_CLEAR;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign in_ready   = count_q != 2'(QUEUE_DEPTH);
	assign push       = in_valid && in_ready;
	assign head.valid = count_q != '0;
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= dec;
	end

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue fill count did not grow on a lone push");
`endif

endmodule

/* sv/roit_div.sv */
// Restoring divider, one quotient bit per cycle, shared by fixed-mode commands.
// Depends on roit_pkg.
module roit_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [roit_pkg::POS_W-1:0]  dividend,
	input  logic [roit_pkg::EB_W-1:0]   divisor,
	output logic                        busy,
	output logic [roit_pkg::POS_W-1:0]  quotient,
	output logic [roit_pkg::EB_W-1:0]   remainder
);
	import roit_pkg::*;

	localparam int CNT_W = $clog2(POS_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] quo_q;
	logic [EB_W-1:0]  rem_q;
	logic [EB_W-1:0]  dvs_q;
	logic [EB_W:0]    trial;
	logic             ge;
	logic [EB_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[POS_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(POS_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[EB_W-1:0] : trial[EB_W-1:0];
			quo_q <= {quo_q[POS_W-2:0], ge};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* sv/roit_back.sv */
// Back end: configuration, totals, offset memory, command sequencer, result register.
// Depends on roit_pkg and roit_div.
module roit_back #(
	parameter int MAX_RECORDS = roit_pkg::DEF_MAX_RECORDS,
	parameter int OFFSET_BITS = roit_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [roit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [roit_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  roit_pkg::queue_head_t           head,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [roit_pkg::STAT_W-1:0]     status,
	output logic [roit_pkg::IDX_W-1:0]      record_count,
	output logic [roit_pkg::ADDR_W-1:0]     record_address,
	output logic [roit_pkg::BYTES_W-1:0]    record_length,
	output logic [roit_pkg::IDX_W-1:0]      found_index,
	output logic [roit_pkg::BYTES_W-1:0]    pre_bytes,
	output logic [roit_pkg::BYTES_W-1:0]    post_bytes,
	output logic                            post_valid
);
	import roit_pkg::*;

	localparam int OB = OFFSET_BITS;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int NW = (CW > IDX_W) ? CW : IDX_W;
	localparam int PW = (OB > POS_W) ? OB : POS_W;
	localparam int SW = ((OB > LEN_W) ? OB : LEN_W) + 1;
	localparam int KW = ((CW > LEN_W) ? CW : LEN_W) + 1;
	localparam logic [OB-1:0] LIMIT = '1;

	// Configuration and table totals.
	logic              layout_q;
	logic [EB_W-1:0]   entry_q;
	logic [ADDR_W-1:0] base_q;
	logic [CW-1:0]     total_q;
	logic [OB-1:0]     bytes_q;

	// Command in flight.
	state_t            state_q, state_d;
	op_t               op_q;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  idx_q;
	logic [POS_W-1:0]  pos_q;
	logic [CW-1:0]     lo_q, hi_q;
	logic [OB-1:0]     start_q;
	logic [OB-1:0]     prod_q;

	// Work result and output register.
	logic [STAT_W-1:0]  wst_q;
	logic [ADDR_W-1:0]  waddr_q;
	logic [BYTES_W-1:0] wlen_q, wpre_q, wpost_q;
	logic [IDX_W-1:0]   wfound_q;
	logic               wpv_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_st_q;
	logic [IDX_W-1:0]   out_cnt_q, out_found_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [BYTES_W-1:0] out_len_q, out_pre_q, out_post_q;
	logic               out_pv_q;

	// Offset memory.
	logic [OB-1:0] mem [MAX_RECORDS];
	logic [OB-1:0] rdata_q;
	logic          rd_en, mem_we;
	logic [AW-1:0] rd_addr;

	// Divider.
	logic              div_start, div_busy;
	logic [POS_W-1:0]  div_dividend, div_quo;
	logic [EB_W-1:0]   div_rem;

	// Decisions.
	logic [EB_W-1:0]        sz;
	logic                   out_free;
	logic                   q_bad, s_bad, s_end, empty, pos_bad, last;
	logic [SW-1:0]          app_sum;
	logic                   byte_ovf, var_full, fix_full;
	logic [KW-1:0]          cnt_sum;
	logic [CW-1:0]          span, mid;
	logic                   more;
	logic [OB-1:0]          start_v;
	logic [IDX_W+EB_W-1:0]  mul;
	logic [NW-1:0]          idx_n, tot_n, idx_next;

	assign sz       = (entry_q == '0) ? EB_W'(1) : entry_q;
	assign out_free = !out_valid_q || out_ready;
	assign idx_n    = NW'(idx_q);
	assign tot_n    = NW'(total_q);
	assign idx_next = idx_n + NW'(1);
	assign q_bad    = idx_n >= tot_n;
	assign s_bad    = idx_n > tot_n;
	assign s_end    = idx_n == tot_n;
	assign last     = idx_next == tot_n;
	assign empty    = total_q == '0;
	assign pos_bad  = PW'(pos_q) > PW'(bytes_q);
	assign app_sum  = SW'(bytes_q) + SW'(len_q);
	assign byte_ovf = app_sum > SW'(LIMIT);
	assign var_full = (total_q >= CW'(MAX_RECORDS)) || byte_ovf;
	assign cnt_sum  = KW'(total_q) + KW'(div_quo[LEN_W-1:0]);
	assign fix_full = (cnt_sum > KW'(MAX_RECORDS)) || byte_ovf;
	assign span     = hi_q - lo_q;
	assign more     = span > CW'(1);
	assign mid      = lo_q + (span >> 1);
	assign start_v  = layout_q ? prod_q : rdata_q;
	assign mul      = idx_q * sz;

	roit_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (sz),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		div_start    = 1'b0;
		div_dividend = pos_q;
		rd_en        = 1'b0;
		rd_addr      = AW'(idx_q);
		mem_we       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (op_q)
					OP_APPEND: begin
						if (layout_q) begin
							div_start    = 1'b1;
							div_dividend = POS_W'(len_q);
							state_d      = ST_DIV;
						end else begin
							mem_we  = !var_full;
							state_d = ST_FIN;
						end
					end
					OP_QUERY: begin
						if (q_bad) begin
							state_d = ST_FIN;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_GOT_START;
						end
					end
					OP_LOCATE: begin
						if (pos_bad) begin
							state_d = ST_FIN;
						end else if (layout_q) begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end else if (empty) begin
							state_d = ST_FIN;
						end else begin
							state_d = ST_SEARCH;
						end
					end
					OP_SPLIT: begin
						if (empty || s_bad || s_end) begin
							state_d = ST_FIN;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_GOT_START;
						end
					end
					OP_CLEAR, OP_NOP: state_d = ST_FIN;
				endcase
			end
			ST_DIV: begin
				if (!div_busy) state_d = ST_FIN;
			end
			ST_GOT_START: begin
				if (op_q == OP_QUERY && !layout_q && !last) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_next);
					state_d = ST_GOT_END;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_GOT_END: state_d = ST_FIN;
			ST_SEARCH: begin
				if (more) begin
					rd_en   = 1'b1;
					rd_addr = AW'(mid);
					state_d = ST_PROBE;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_PROBE: state_d = ST_SEARCH;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			layout_q    <= 1'b0;
			entry_q     <= EB_W'(1);
			base_q      <= '0;
			total_q     <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_LAYOUT_MODE: begin
						layout_q <= cfg_wdata[0];
						total_q  <= '0;
						bytes_q  <= '0;
					end
					REG_ENTRY_BYTES: begin
						entry_q <= cfg_wdata[EB_W-1:0];
						total_q <= '0;
						bytes_q <= '0;
					end
					REG_BASE_ADDRESS: base_q <= cfg_wdata[ADDR_W-1:0];
					default: ;
				endcase
			end else if (state_q == ST_DISPATCH && op_q == OP_CLEAR) begin
				total_q <= '0;
				bytes_q <= '0;
			end else if (mem_we) begin
				total_q <= total_q + CW'(1);
				bytes_q <= OB'(app_sum);
			end else if (state_q == ST_DIV && !div_busy && op_q == OP_APPEND &&
					div_rem == '0 && !fix_full) begin
				total_q <= CW'(cnt_sum);
				bytes_q <= OB'(app_sum);
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[AW'(total_q)] <= bytes_q;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					op_q     <= head.item.op;
					len_q    <= head.item.length;
					idx_q    <= head.item.index;
					pos_q    <= head.item.position;
					wst_q    <= STAT_OK;
					waddr_q  <= '0;
					wlen_q   <= '0;
					wfound_q <= '0;
					wpre_q   <= '0;
					wpost_q  <= '0;
					wpv_q    <= 1'b0;
				end
			end
			ST_DISPATCH: begin
				prod_q <= OB'(mul);
				lo_q   <= '0;
				hi_q   <= total_q;
				unique case (op_q)
					OP_APPEND: begin
						if (!layout_q && var_full) wst_q <= STAT_FULL;
					end
					OP_QUERY: begin
						if (q_bad) wst_q <= STAT_BAD_INDEX;
					end
					OP_LOCATE: begin
						if (pos_bad) wst_q <= STAT_BAD_POS;
						else if (!layout_q && empty) wst_q <= STAT_EMPTY;
					end
					OP_SPLIT: begin
						if (empty) begin
							wst_q <= STAT_EMPTY;
						end else if (s_bad) begin
							wst_q <= STAT_BAD_INDEX;
						end else if (s_end) begin
							wpre_q  <= BYTES_W'(bytes_q);
							wpost_q <= '0;
						end
					end
					OP_CLEAR, OP_NOP: ;
				endcase
			end
			ST_DIV: begin
				if (!div_busy) begin
					if (op_q == OP_APPEND) begin
						if (div_rem != '0) wst_q <= STAT_NOT_MULT;
						else if (fix_full) wst_q <= STAT_FULL;
					end else begin
						wfound_q <= IDX_W'(div_quo);
					end
				end
			end
			ST_GOT_START: begin
				start_q <= start_v;
				waddr_q <= base_q + ADDR_W'(start_v);
				if (op_q == OP_QUERY) begin
					if (layout_q) wlen_q <= BYTES_W'(sz);
					else if (last) wlen_q <= BYTES_W'(bytes_q - start_v);
				end else begin
					wpre_q  <= BYTES_W'(start_v);
					wpost_q <= BYTES_W'(bytes_q - start_v);
					wpv_q   <= 1'b1;
				end
			end
			ST_GOT_END: wlen_q <= BYTES_W'(rdata_q - start_q);
			ST_SEARCH: begin
				if (!more) wfound_q <= IDX_W'(lo_q);
			end
			ST_PROBE: begin
				if (PW'(rdata_q) <= PW'(pos_q)) lo_q <= mid;
				else hi_q <= mid;
			end
			ST_FIN: begin
				if (out_free) begin
					out_st_q    <= wst_q;
					out_cnt_q   <= IDX_W'(total_q);
					out_addr_q  <= waddr_q;
					out_len_q   <= wlen_q;
					out_found_q <= wfound_q;
					out_pre_q   <= wpre_q;
					out_post_q  <= wpost_q;
					out_pv_q    <= wpv_q;
				end
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign record_count   = out_cnt_q;
	assign record_address = out_addr_q;
	assign record_length  = out_len_q;
	assign found_index    = out_found_q;
	assign pre_bytes      = out_pre_q;
	assign post_bytes     = out_post_q;
	assign post_valid     = out_pv_q;

`ifndef ASSERT_OFF
	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_RECORDS))
		else $error("record count exceeds the table size");
	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> out_valid_q)
		else $error("finished command did not reach the result register");
`endif

endmodule

/* sv/record_offset_index_table.sv */
// Top level of the record offset index table.
// Depends on roit_pkg, roit_front and roit_back.
//
// Indexes records packed back to back in one byte buffer: append, entry query,
// position-to-index, split query and clear, one result transfer per input
// transfer. A two-entry queue sits between the decoding front end and the
// sequencer, and the result sits in its own register, so input transfers keep
// being taken while a result waits. One command is executed at a time: a
// variable append, clear or error goes from dispatch straight to the finish
// state, a split or entry query fetches the record's start offset and, for
// a variable-mode query that is not the last record, its end offset, a
// variable-mode position lookup runs a binary search with one offset memory
// read per probe, and a fixed-mode append or lookup runs through a bit-serial
// divider one quotient bit per cycle. The offset memory needs no clearing
// pass: only entries below the record count are read. Writes to layout_mode
// or entry_bytes empty the table and must be made while the block is idle.
module record_offset_index_table #(
	parameter int MAX_RECORDS = roit_pkg::DEF_MAX_RECORDS,
	parameter int OFFSET_BITS = roit_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [roit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [roit_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [roit_pkg::CMD_W-1:0]      command,
	input  logic [roit_pkg::LEN_W-1:0]      length,
	input  logic [roit_pkg::IDX_W-1:0]      index,
	input  logic [roit_pkg::POS_W-1:0]      position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [roit_pkg::STAT_W-1:0]     status,
	output logic [roit_pkg::IDX_W-1:0]      record_count,
	output logic [roit_pkg::ADDR_W-1:0]     record_address,
	output logic [roit_pkg::BYTES_W-1:0]    record_length,
	output logic [roit_pkg::IDX_W-1:0]      found_index,
	output logic [roit_pkg::BYTES_W-1:0]    pre_bytes,
	output logic [roit_pkg::BYTES_W-1:0]    post_bytes,
	output logic                            post_valid
);
	import roit_pkg::*;

	queue_head_t head;
	logic        pop;

	// Decode and queue each input transfer.
	roit_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.length   (length),
		.index    (index),
		.position (position),
		.head     (head),
		.pop      (pop)
	);

	// Execute queued commands against the table and hold the result.
	roit_back #(
		.MAX_RECORDS (MAX_RECORDS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.record_count   (record_count),
		.record_address (record_address),
		.record_length  (record_length),
		.found_index    (found_index),
		.pre_bytes      (pre_bytes),
		.post_bytes     (post_bytes),
		.post_valid     (post_valid)
	);

endmodule
